// ----- hdl/bffra_pkg.sv -----
// ----------------------------------------------------------------------------
// bffra_pkg: shared types and constants of the first-fit run allocator
// Transfer payloads, register indexes, action codes, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bffra_pkg;

	// default sizing
	localparam int NUM_BLOCKS_DEF      = 65536;
	localparam int MAP_SECTOR_BITS_DEF = 4096;

	// bitmap memory word
	localparam int WORD_BITS = 64;
	localparam int WORD_AW   = $clog2(WORD_BITS);

	// configuration register widths
	localparam int CFG_W = 17;
	localparam int TB_W  = 17;
	localparam int MS_W  = 5;

	// register indexes
	localparam logic [0:0] REG_TOTAL_BLOCKS = 1'b0;
	localparam logic [0:0] REG_MAP_SECTORS  = 1'b1;

	// request actions
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_MARK  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] first_block;
		logic [15:0] range_len;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [15:0] run_start;
	} resp_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CLEAR,
		OP_LOAD,
		OP_SCAN_SETUP,
		OP_SCAN_LOAD,
		OP_SCAN_STEP,
		OP_RANGE_SETUP,
		OP_RANGE_PRIME,
		OP_RANGE_STEP
	} op_t;

	typedef struct packed {
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       clear_last;
		logic [1:0] action;
		logic       scan_early_fail;
		logic       scan_found;
		logic       scan_fail;
		logic       range_empty;
		logic       range_last;
	} sts_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN_SETUP,
		ST_SCAN_LOAD,
		ST_SCAN,
		ST_RANGE_SETUP,
		ST_RANGE_PRIME,
		ST_RANGE,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/bffra_dp.sv -----
// ----------------------------------------------------------------------------
// bffra_dp: bitmap datapath of the first-fit run allocator
// Holds the configuration, the used/free bitmap memory (one word per cycle),
// the run scanner that walks free segments word by word, and the range
// read-modify-write path.
// ----------------------------------------------------------------------------
module bffra_dp #(
	parameter int NUM_BLOCKS      = bffra_pkg::NUM_BLOCKS_DEF,
	parameter int MAP_SECTOR_BITS = bffra_pkg::MAP_SECTOR_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_idx,
	input  logic [bffra_pkg::CFG_W-1:0] cfg_wdata,
	input  bffra_pkg::req_t           in_data,
	input  bffra_pkg::cmd_t           cmd,
	output bffra_pkg::sts_t           sts,
	output bffra_pkg::resp_t          out_data
);
	import bffra_pkg::*;

	localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int AW_N      = $clog2(NUM_BLOCKS) + 1;
	localparam int AW_P      = MS_W + $clog2(MAP_SECTOR_BITS) + 1;
	localparam int AW_R      = 18;
	localparam int AW_NP     = (AW_N > AW_P) ? AW_N : AW_P;
	localparam int AW        = (AW_NP > AW_R) ? AW_NP : AW_R;
	localparam int PW        = WORD_AW + 1;

	// lowest set bit of v at or above from; WORD_BITS when none
	function automatic logic [PW-1:0] first_set_from(
		input logic [WORD_BITS-1:0] v,
		input logic [PW-1:0]        from
	);
		logic [PW-1:0] r;
		r = PW'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i] && (PW'(i) >= from))
				r = PW'(i);
		end
		return r;
	endfunction

	// blocks of the word at base that lie at or beyond lim read as used
	function automatic logic [WORD_BITS-1:0] tail_mask(
		input logic [AW-1:0] base,
		input logic [AW-1:0] lim
	);
		logic [AW-1:0]        d;
		logic [WORD_BITS-1:0] m;
		d = lim - base;
		if (base >= lim)
			m = {WORD_BITS{1'b1}};
		else if (d >= AW'(WORD_BITS))
			m = '0;
		else
			m = {WORD_BITS{1'b1}} << d[WORD_AW-1:0];
		return m;
	endfunction

	// configuration registers
	logic [TB_W-1:0] tb_q;
	logic [MS_W-1:0] ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q <= '0;
			ms_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TOTAL_BLOCKS: tb_q <= cfg_wdata[TB_W-1:0];
				REG_MAP_SECTORS:  ms_q <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// covered limit and scan end
	logic [AW-1:0] prod, lim, scan_end;
	assign prod     = AW'(ms_q) * AW'(MAP_SECTOR_BITS);
	assign lim      = (prod > AW'(NUM_BLOCKS)) ? AW'(NUM_BLOCKS) : prod;
	assign scan_end = (AW'(tb_q) < lim) ? AW'(tb_q) : lim;

	// request and working registers
	logic [1:0]           act_q;
	logic [15:0]          first_q, count_q;
	logic [AW-1:0]        pos_q, rstart_q, rlo_q, rend_q;
	logic [15:0]          c_q;
	logic [WORD_BITS-1:0] cur_q, rd_q;
	logic                 set_q;
	logic                 res_status_q;
	logic [15:0]          res_start_q;
	resp_t                out_q;
	logic [WIW-1:0]       clr_q;

	// bitmap memory
	logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
	logic                 mem_we;
	logic [WIW-1:0]       mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)
			bitmap_mem[mem_waddr] <= mem_wdata;
		rd_q <= bitmap_mem[mem_raddr];
	end

	// scanner: one free segment or one word boundary per cycle
	logic [WORD_AW-1:0] pos_off;
	logic [AW-1:0]      pos_base, nbase, start_cand;
	logic [PW-1:0]      fu, ff, seg;
	logic [16:0]        tot;
	logic               found, advance;

	assign pos_off    = pos_q[WORD_AW-1:0];
	assign pos_base   = {pos_q[AW-1:WORD_AW], WORD_AW'(0)};
	assign nbase      = pos_base + AW'(WORD_BITS);
	assign fu         = first_set_from(cur_q, {1'b0, pos_off});
	assign ff         = first_set_from(~cur_q, fu);
	assign seg        = fu - {1'b0, pos_off};
	assign tot        = {1'b0, c_q} + 17'(seg);
	assign found      = tot >= {1'b0, count_q};
	assign advance    = (fu == PW'(WORD_BITS)) || (ff == PW'(WORD_BITS));
	assign start_cand = (c_q == '0) ? pos_q : rstart_q;

	// range read-modify-write
	logic [AW-1:0]        rend_m1, nrlo, req_end, req_rend;
	logic [WIW-1:0]       rlo_word;
	logic                 rng_last;
	logic [WORD_AW-1:0]   lo_bit, hi_bit;
	logic [WORD_BITS-1:0] rmask, rng_wdata;

	assign rend_m1   = rend_q - AW'(1);
	assign rlo_word  = rlo_q[WORD_AW +: WIW];
	assign nrlo      = {rlo_q[AW-1:WORD_AW], WORD_AW'(0)} + AW'(WORD_BITS);
	assign rng_last  = rlo_q[AW-1:WORD_AW] == rend_m1[AW-1:WORD_AW];
	assign lo_bit    = rlo_q[WORD_AW-1:0];
	assign hi_bit    = rng_last ? rend_m1[WORD_AW-1:0] : {WORD_AW{1'b1}};
	assign rmask     = ({WORD_BITS{1'b1}} << lo_bit)
	                 & ({WORD_BITS{1'b1}} >> (WORD_AW'(WORD_BITS - 1) - hi_bit));
	assign rng_wdata = set_q ? (rd_q | rmask) : (rd_q & ~rmask);
	assign req_end   = AW'(first_q) + AW'(count_q);
	assign req_rend  = (req_end < lim) ? req_end : lim;

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rlo_word;
		mem_wdata = rng_wdata;
		case (cmd.op)
			OP_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			OP_RANGE_STEP: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_RANGE_PRIME: mem_raddr = rlo_word;
			OP_RANGE_STEP:  mem_raddr = rlo_word + WIW'(1);
			OP_SCAN_SETUP:  mem_raddr = '0;
			// keep one word ahead of the word the scan moves into
			OP_SCAN_STEP:   mem_raddr = pos_q[WORD_AW +: WIW] + (advance ? WIW'(2) : WIW'(1));
			default:        mem_raddr = pos_q[WORD_AW +: WIW] + WIW'(1);
		endcase
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.op == OP_CLEAR)
			clr_q <= clr_q + WIW'(1);
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				act_q        <= in_data.action;
				first_q      <= in_data.first_block;
				count_q      <= in_data.range_len;
				res_status_q <= 1'b0;
				res_start_q  <= '0;
			end
			OP_SCAN_SETUP: begin
				pos_q        <= AW'(1);
				c_q          <= '0;
				res_status_q <= 1'b1;
			end
			OP_SCAN_LOAD: cur_q <= rd_q | tail_mask(pos_base, scan_end);
			OP_SCAN_STEP: begin
				if (found) begin
					res_status_q <= 1'b0;
					res_start_q  <= start_cand[15:0];
					rlo_q        <= start_cand;
					rend_q       <= start_cand + AW'(count_q);
					set_q        <= 1'b1;
				end else if (advance) begin
					pos_q    <= nbase;
					c_q      <= (fu == PW'(WORD_BITS)) ? tot[15:0] : '0;
					rstart_q <= start_cand;
					cur_q    <= rd_q | tail_mask(nbase, scan_end);
				end else begin
					pos_q <= pos_base + AW'(ff);
					c_q   <= '0;
				end
			end
			OP_RANGE_SETUP: begin
				rlo_q  <= AW'(first_q);
				rend_q <= req_rend;
				set_q  <= act_q == ACT_MARK;
			end
			OP_RANGE_STEP: rlo_q <= nrlo;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q.status    <= res_status_q;
			out_q.run_start <= res_start_q;
		end
	end

	// status towards the controller
	assign sts.clear_last      = clr_q == WIW'(NUM_WORDS - 1);
	assign sts.action          = act_q;
	assign sts.scan_early_fail = (count_q == '0) || (scan_end <= AW'(1));
	assign sts.scan_found      = found;
	assign sts.scan_fail       = !found && advance && (nbase >= scan_end);
	assign sts.range_empty     = rlo_q >= rend_q;
	assign sts.range_last      = rng_last;
	assign out_data            = out_q;

`ifndef SYNTH
	a_range_step_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RANGE_STEP |-> !sts.range_empty)
		else $error("range step on an empty range");
	a_run_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SCAN_STEP |-> c_q < count_q)
		else $error("carried run already reached the count");
	a_found_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SCAN_STEP) && found |-> start_cand + AW'(count_q) <= scan_end)
		else $error("found run passes the scan end");
	a_found_not_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SCAN_STEP) && found |-> start_cand != '0)
		else $error("run starts at block zero");
`endif

endmodule

// ----- hdl/bffra_ctrl.sv -----
// ----------------------------------------------------------------------------
// bffra_ctrl: sequencing controller of the first-fit run allocator
// Runs the clearing pass after reset, takes one request at a time, steps the
// datapath through scan and range phases and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module bffra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output bffra_pkg::cmd_t cmd,
	input  bffra_pkg::sts_t sts
);
	import bffra_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.op       = OP_IDLE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.action) inside
					ACT_ALLOC:          state_d = ST_SCAN_SETUP;
					ACT_FREE, ACT_MARK: state_d = ST_RANGE_SETUP;
					default:            state_d = ST_DONE;
				endcase
			end
			ST_SCAN_SETUP: begin
				cmd.op  = OP_SCAN_SETUP;
				state_d = sts.scan_early_fail ? ST_DONE : ST_SCAN_LOAD;
			end
			ST_SCAN_LOAD: begin
				cmd.op  = OP_SCAN_LOAD;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN_STEP;
				if (sts.scan_found)
					state_d = ST_RANGE_PRIME;
				else if (sts.scan_fail)
					state_d = ST_DONE;
			end
			ST_RANGE_SETUP: begin
				cmd.op  = OP_RANGE_SETUP;
				state_d = ST_RANGE_PRIME;
			end
			ST_RANGE_PRIME: begin
				cmd.op  = OP_RANGE_PRIME;
				state_d = sts.range_empty ? ST_DONE : ST_RANGE;
			end
			ST_RANGE: begin
				cmd.op = OP_RANGE_STEP;
				if (sts.range_last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DISPATCH)
		else $error("accepted request not dispatched");
	a_found_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && sts.scan_found |=> state_q == ST_RANGE_PRIME)
		else $error("found run not marked");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_valid && !out_ready |=> state_q == ST_DONE)
		else $error("result overwritten while stalled");
`endif

endmodule

// ----- hdl/bitmap_first_fit_run_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_fit_run_allocator_top: first-fit contiguous block allocator
// Used/free bitmap over storage blocks with allocate, free and mark-used
// requests; controller and datapath joined by command and status groups.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready, one transfer per request; each
//   gives exactly one result transfer on out_valid/out_ready.
//   Configuration (total_blocks, map_sectors) is written through cfg_we,
//   cfg_idx, cfg_wdata while no request is in flight.
// Sequence:
//   After reset the bitmap memory is cleared one word a cycle with
//   in_ready low. Free and mark: setup and prime, then a read-modify-write
//   of each 64-bit bitmap word touched. Allocate: scan setup and scan load,
//   then a scan step for each bitmap word passed and each used stretch met
//   inside a word, then prime and a read-modify-write of each word of the
//   run marked; a zero count or empty scan area ends after scan setup.
// Stalls:
//   A finished result sits in the output register; the next request is
//   accepted meanwhile. A request that finishes while the previous result
//   still waits is held until out_ready.
// ----------------------------------------------------------------------------
module bitmap_first_fit_run_allocator_top #(
	parameter int NUM_BLOCKS      = bffra_pkg::NUM_BLOCKS_DEF,
	parameter int MAP_SECTOR_BITS = bffra_pkg::MAP_SECTOR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_idx,
	input  logic [bffra_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bffra_pkg::req_t             in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bffra_pkg::resp_t            out_data
);
	import bffra_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	bffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// bitmap and scanner
	bffra_dp #(
		.NUM_BLOCKS      (NUM_BLOCKS),
		.MAP_SECTOR_BITS (MAP_SECTOR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule
